// File: rtl/uvs_pkg.sv
// Shared types, constants and helpers for the UV sphere vertex generator.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none
package uvs_pkg;

  // Segment registers larger than this count are clamped to it.
  localparam int unsigned MaxSegments = 255;

  // Register indexes of the configuration port.
  localparam logic CfgColSegments = 1'b0;
  localparam logic CfgRowSegments = 1'b1;

  // Pipeline shape: one quotient bit per divider stage, four sine stages.
  localparam int DivSteps    = 17;
  localparam int SineStages  = 4;
  localparam int SideStages  = SineStages + 1;

  // Quarter-wave sine polynomial coefficients, Q30.
  localparam logic [30:0] PolyA = 31'd1686629713;
  localparam logic [26:0] PolyC = 27'd76016977;
  localparam logic [29:0] PolyB = 30'd688904866;

  typedef struct packed {
    logic [7:0] col_index;
    logic [7:0] row_index;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               quad_valid;
    logic [15:0]        tri0_a;
    logic [15:0]        tri0_b;
    logic [15:0]        tri0_c;
    logic [15:0]        tri1_a;
    logic [15:0]        tri1_b;
    logic [15:0]        tri1_c;
  } out_t;

  // Quad indices that ride alongside the arithmetic.
  typedef struct packed {
    logic        quad;
    logic [15:0] base;
    logic [15:0] next;
  } quad_t;

  // Rounded magnitude to Q1.15 with sign applied and saturation.
  function automatic logic [15:0] sat_q15(input logic [16:0] r, input logic neg);
    logic [16:0] rr;
    begin
      if (neg) begin
        rr = (r > 17'd32768) ? 17'd32768 : r;
        sat_q15 = 16'(17'h10000 - rr);
      end else begin
        sat_q15 = (r > 17'd32767) ? 16'h7fff : r[15:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/uv_sphere_vertex_gen.sv
// UV sphere vertex generator: one grid point in, one vertex with texture
// coordinates and quad indices out, one request per cycle; a stall while a
// finished result waits freezes the whole pipeline. Input stage, 17-stage
// divider, 4-stage sine pipelines, product stage and output register lie
// between request and vertex. Reset clears all valid bits and loads 32
// column and 16 row segments. Depends on uvs_pkg, uvs_div, uvs_sine.
`default_nettype none
module uv_sphere_vertex_gen (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [7:0]    cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire uvs_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output uvs_pkg::out_t      out_data_o
);
  import uvs_pkg::*;

  localparam int ValidDepth = 1 + DivSteps + SideStages;

  logic [7:0] col_seg_q, row_seg_q;
  logic       en;
  logic [ValidDepth-1:0] vld_q;
  logic       out_valid_q;
  out_t       out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_seg_q <= 8'd32;
      row_seg_q <= 8'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgColSegments: col_seg_q <= cfg_data_i;
        CfgRowSegments: row_seg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished result is held back.
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Input stage: clamp, build the dividends and the quad indices.
  logic [7:0]  xs, ys, col, row;
  logic [8:0]  xs1;
  logic [16:0] base, next;
  quad_t       quad_in;
  logic [23:0] numu_q, numv_q, nump_q;
  logic [7:0]  xs_q, ys_q;
  quad_t       quad0_q;

  always_comb begin
    xs = (32'(col_seg_q) > MaxSegments) ? 8'(MaxSegments) : col_seg_q;
    ys = (32'(row_seg_q) > MaxSegments) ? 8'(MaxSegments) : row_seg_q;
    if (xs == 8'd0) xs = 8'd1;
    if (ys == 8'd0) ys = 8'd1;
    col  = (in_data_i.col_index > xs) ? xs : in_data_i.col_index;
    row  = (in_data_i.row_index > ys) ? ys : in_data_i.row_index;
    xs1  = {1'b0, xs} + 9'd1;
    base = 17'(17'(row) * 17'(xs1)) + 17'(col);
    next = base + 17'(xs1);
    quad_in.quad = (col < xs) && (row < ys);
    quad_in.base = quad_in.quad ? base[15:0] : 16'd0;
    quad_in.next = quad_in.quad ? next[15:0] : 16'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      numu_q  <= {col, 16'd0} + 24'(xs >> 1);
      numv_q  <= {row, 16'd0} + 24'(ys >> 1);
      nump_q  <= {1'b0, row, 15'd0} + 24'(ys >> 1);
      xs_q    <= xs;
      ys_q    <= ys;
      quad0_q <= quad_in;
    end
  end

  // Valid bits march with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[ValidDepth-2:0], in_valid_i};
      out_valid_q <= vld_q[ValidDepth-1];
    end
  end

  // Three dividers: azimuth/texture u, texture v, polar phase.
  logic [16:0] tu, tv, pv;

  uvs_div u_div_u (.clk_i, .en_i(en), .num_i(numu_q), .den_i(xs_q), .quo_o(tu));
  uvs_div u_div_v (.clk_i, .en_i(en), .num_i(numv_q), .den_i(ys_q), .quo_o(tv));
  uvs_div u_div_p (.clk_i, .en_i(en), .num_i(nump_q), .den_i(ys_q), .quo_o(pv));

  // Quad indices follow the divider.
  quad_t quad_d_q [DivSteps];

  always_ff @(posedge clk_i) begin
    if (en) begin
      quad_d_q[0] <= quad0_q;
      for (int i = 1; i < DivSteps; i++) begin
        quad_d_q[i] <= quad_d_q[i-1];
      end
    end
  end

  // Four sine evaluations of the azimuth and polar angles.
  logic [30:0] su, cu, sv, cv;
  logic        nsu, ncu, nsv, ncv;
  logic [15:0] ph_su, ph_cu, ph_sv, ph_cv;

  assign ph_su = tu[15:0];
  assign ph_cu = tu[15:0] + 16'd16384;
  assign ph_sv = pv[15:0];
  assign ph_cv = pv[15:0] + 16'd16384;

  uvs_sine u_sin_u (.clk_i, .en_i(en), .phase_i(ph_su), .mag_o(su), .neg_o(nsu));
  uvs_sine u_cos_u (.clk_i, .en_i(en), .phase_i(ph_cu), .mag_o(cu), .neg_o(ncu));
  uvs_sine u_sin_v (.clk_i, .en_i(en), .phase_i(ph_sv), .mag_o(sv), .neg_o(nsv));
  uvs_sine u_cos_v (.clk_i, .en_i(en), .phase_i(ph_cv), .mag_o(cv), .neg_o(ncv));

  // Texture coordinates and indices follow the sine stages and the product.
  quad_t       quad_s_q [SideStages];
  logic [16:0] tu_s_q   [SideStages];
  logic [16:0] tv_s_q   [SideStages];

  always_ff @(posedge clk_i) begin
    if (en) begin
      quad_s_q[0] <= quad_d_q[DivSteps-1];
      tu_s_q[0]   <= tu;
      tv_s_q[0]   <= tv;
      for (int i = 1; i < SideStages; i++) begin
        quad_s_q[i] <= quad_s_q[i-1];
        tu_s_q[i]   <= tu_s_q[i-1];
        tv_s_q[i]   <= tv_s_q[i-1];
      end
    end
  end

  // Product stage for x and z; y is passed through.
  logic [61:0] px_q, pz_q;
  logic [30:0] cv_q;
  logic        nx_q, ny_q, nz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= 62'(cu) * 62'(sv);
      pz_q <= 62'(su) * 62'(sv);
      cv_q <= cv;
      nx_q <= ncu ^ nsv;
      ny_q <= ncv;
      nz_q <= nsu ^ nsv;
    end
  end

  // Output stage: round, saturate, and lay out the triangle indices.
  logic [61:0] rx, rz;
  logic [31:0] ry;
  quad_t       qo;

  always_comb begin
    rx = (px_q + (62'd1 << 44)) >> 45;
    rz = (pz_q + (62'd1 << 44)) >> 45;
    ry = (32'(cv_q) + (32'd1 << 14)) >> 15;
    qo = quad_s_q[SideStages-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.pos_x      <= sat_q15(rx[16:0], nx_q);
      out_q.pos_y      <= sat_q15(ry[16:0], ny_q);
      out_q.pos_z      <= sat_q15(rz[16:0], nz_q);
      out_q.tex_u      <= tu_s_q[SideStages-1];
      out_q.tex_v      <= tv_s_q[SideStages-1];
      out_q.quad_valid <= qo.quad;
      out_q.tri0_a     <= qo.next;
      out_q.tri0_b     <= qo.base;
      out_q.tri0_c     <= qo.quad ? qo.base + 16'd1 : 16'd0;
      out_q.tri1_a     <= qo.next;
      out_q.tri1_b     <= qo.quad ? qo.base + 16'd1 : 16'd0;
      out_q.tri1_c     <= qo.quad ? qo.next + 16'd1 : 16'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: rtl/uvs_div.sv
// Pipelined restoring divider: 24-bit dividend by 8-bit divisor, one quotient
// bit per stage. Uses uvs_pkg; the quotient must fit in DivSteps bits.
`default_nettype none
module uvs_div (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [23:0] num_i,
  input  wire logic [7:0]  den_i,
  output logic [16:0]      quo_o
);
  import uvs_pkg::*;

  logic [7:0]  rem_q [DivSteps];
  logic [23:0] num_q [DivSteps];
  logic [16:0] quo_q [DivSteps];
  logic [7:0]  den_q [DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [7:0]  rin;
    logic [23:0] nin;
    logic [16:0] qin;
    logic [7:0]  din;
    logic [8:0]  r9;
    logic        ge;

    // Stage inputs: the top bits of the dividend seed the remainder.
    if (i == 0) begin : g_first
      assign rin = {1'b0, num_i[23:17]};
      assign nin = num_i;
      assign qin = '0;
      assign din = den_i;
    end else begin : g_next
      assign rin = rem_q[i-1];
      assign nin = num_q[i-1];
      assign qin = quo_q[i-1];
      assign din = den_q[i-1];
    end

    // Shift in one dividend bit and try a subtract.
    assign r9 = {rin, nin[DivSteps-1-i]};
    assign ge = (r9 >= {1'b0, din});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? 8'(r9 - {1'b0, din}) : r9[7:0];
        num_q[i] <= nin;
        quo_q[i] <= {qin[15:0], ge};
        den_q[i] <= din;
      end
    end
  end

  assign quo_o = quo_q[DivSteps-1];

endmodule
`default_nettype wire

// File: rtl/uvs_sine.sv
// Four-stage sine of a Q0.16 phase: quadrant fold, then the odd polynomial
// evaluated one product per stage. Uses uvs_pkg for the coefficients.
`default_nettype none
module uvs_sine (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] phase_i,
  output logic [30:0]      mag_o,
  output logic             neg_o
);
  import uvs_pkg::*;

  logic [16:0] t_a_q, t2_a_q, t_b_q, t2_b_q, t_c_q;
  logic [29:0] inner_b_q;
  logic [30:0] mid_c_q, mag_q;
  logic        neg_a_q, neg_b_q, neg_c_q, neg_q;

  logic [16:0] t_fold;
  logic [33:0] tt;
  logic [43:0] ct;
  logic [46:0] it;
  logic [47:0] mt;

  // Fold the phase into the first quadrant; odd quadrants run backwards.
  always_comb begin
    t_fold = {1'b0, phase_i[13:0], 2'b00};
    if (phase_i[14]) begin
      t_fold = 17'h10000 - t_fold;
    end
    tt = 34'(t_fold) * 34'(t_fold);
    ct = 44'(PolyC) * 44'(t2_a_q);
    it = 47'(inner_b_q) * 47'(t2_b_q);
    mt = 48'(mid_c_q) * 48'(t_c_q);
  end

  // One multiply between each pair of registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_a_q     <= t_fold;
      t2_a_q    <= 17'(tt >> 16);
      neg_a_q   <= phase_i[15];
      t_b_q     <= t_a_q;
      t2_b_q    <= t2_a_q;
      inner_b_q <= PolyB - 30'(ct >> 16);
      neg_b_q   <= neg_a_q;
      t_c_q     <= t_b_q;
      mid_c_q   <= PolyA - 31'(it >> 16);
      neg_c_q   <= neg_b_q;
      mag_q     <= 31'(mt >> 16);
      neg_q     <= neg_c_q;
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule
`default_nettype wire

// File: tb/sv/uv_sphere_vertex_gen_tb.sv
// Self-checking testbench for the UV sphere vertex generator.
// Depends on uvs_pkg and uv_sphere_vertex_gen; predicts each vertex in-line
// and compares it field by field with the block's output.
`timescale 1ns / 100ps
module uv_sphere_vertex_gen_tb;
  import uvs_pkg::*;

  localparam int Latency = 24;
  localparam longint QA = 64'd1686629713;
  localparam longint QC = 64'd76016977;
  localparam longint QB = QA + QC - 64'd1073741824;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CfgColSegments;
  logic [7:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  uv_sphere_vertex_gen u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // Shadow copy of the segment registers.
  logic [7:0] col_seg_q, row_seg_q;
  out_t vertex_q[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Stimulus table of the directed part; expected values given for a few rows.
  typedef struct {
    in_t req;
    bit  has_gold;
    out_t gold;
  } vec_t;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint unsigned eff_seg(logic [7:0] r);
    longint unsigned s;
    s = r;
    if (s > MaxSegments) s = MaxSegments;
    if (s == 0) s = 1;
    return s;
  endfunction

  // Quarter-wave sine in Q30 for a Q0.16 argument.
  function automatic longint unsigned quarter_wave(longint unsigned t);
    longint unsigned t2, inner, mid;
    t2 = (t * t) >> 16;
    inner = QB - ((QC * t2) >> 16);
    mid = QA - ((inner * t2) >> 16);
    return (mid * t) >> 16;
  endfunction

  function automatic longint unsigned turn_sine(longint unsigned ph, output bit neg);
    longint unsigned p, q, t;
    p = ph & 64'hffff;
    q = p >> 14;
    t = (p & 64'h3fff) << 2;
    if (q == 1 || q == 3) t = 65536 - t;
    neg = (q >= 2);
    return quarter_wave(t);
  endfunction

  function automatic logic [15:0] round_q15(longint unsigned mag, bit neg, int sh);
    longint unsigned r;
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    if (neg) begin
      if (r > 32768) r = 32768;
      return 16'((64'h10000 - r) & 64'hffff);
    end
    if (r > 32767) r = 32767;
    return 16'(r);
  endfunction

  function automatic out_t vertex_of(in_t req);
    out_t v;
    longint unsigned xs, ys, c, r, tu, tv, pv, su, cu, sv, cv, base, nxt;
    bit nsu, ncu, nsv, ncv;
    xs = eff_seg(col_seg_q);
    ys = eff_seg(row_seg_q);
    c = req.col_index;
    r = req.row_index;
    if (c > xs) c = xs;
    if (r > ys) r = ys;
    tu = (c * 65536 + xs / 2) / xs;
    tv = (r * 65536 + ys / 2) / ys;
    pv = (r * 32768 + ys / 2) / ys;
    su = turn_sine(tu, nsu);
    cu = turn_sine(tu + 16384, ncu);
    sv = turn_sine(pv, nsv);
    cv = turn_sine(pv + 16384, ncv);
    v = '0;
    v.pos_x = round_q15(cu * sv, ncu != nsv, 45);
    v.pos_y = round_q15(cv, ncv, 15);
    v.pos_z = round_q15(su * sv, nsu != nsv, 45);
    v.tex_u = 17'(tu);
    v.tex_v = 17'(tv);
    if (c < xs && r < ys) begin
      base = r * (xs + 1) + c;
      nxt = (r + 1) * (xs + 1) + c;
      v.quad_valid = 1'b1;
      v.tri0_a = 16'(nxt);
      v.tri0_b = 16'(base);
      v.tri0_c = 16'(base + 1);
      v.tri1_a = 16'(nxt);
      v.tri1_b = 16'(base + 1);
      v.tri1_c = 16'(nxt + 1);
    end
    return v;
  endfunction

  // Random receiver stall, changed at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Output checker.
  always @(posedge clk_i) begin
    out_t exp_v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex %p", out_data_o);
      end else begin
        exp_v = vertex_q.pop_front();
        if (out_data_o !== exp_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("vertex mismatch: expected %p got %p", exp_v, out_data_o);
        end
      end
    end
  end

  // Sends one request, honoring the sender idle rate; returns after acceptance.
  task automatic send_point(in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    vertex_q = {vertex_q, vertex_of(req)};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic write_segments(logic [7:0] cols, logic [7:0] rows);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgColSegments;
    cfg_data_i <= cols;
    @(negedge clk_i);
    cfg_idx_i <= CfgRowSegments;
    cfg_data_i <= rows;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    col_seg_q = cols;
    row_seg_q = rows;
  endtask

  // Mostly in-grid points, some beyond the segment counts.
  function automatic in_t random_point();
    in_t p;
    if ($urandom_range(9) < 8) begin
      p.col_index = 8'($urandom_range(32'(eff_seg(col_seg_q))));
      p.row_index = 8'($urandom_range(32'(eff_seg(row_seg_q))));
    end else begin
      p.col_index = 8'($urandom);
      p.row_index = 8'($urandom);
    end
    return p;
  endfunction

  initial begin
    vec_t vecs[$];
    vec_t e;
    out_t g;
    logic [7:0] seg_set[6][2];
    int idle_set[4][2];
    col_seg_q = 8'd32;
    row_seg_q = 8'd16;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part under reset segments 32 x 16.
    g = '0;
    g.pos_y = 16'sd32767;
    g.quad_valid = 1'b1;
    g.tri0_a = 16'd33;
    g.tri0_b = 16'd0;
    g.tri0_c = 16'd1;
    g.tri1_a = 16'd33;
    g.tri1_b = 16'd1;
    g.tri1_c = 16'd34;
    e.req = '{8'd0, 8'd0}; e.has_gold = 1; e.gold = g; vecs = {vecs, e};
    // South pole at the seam corner: no quad.
    g = '0;
    g.pos_y = -16'sd32768;
    g.tex_u = 17'd65536;
    g.tex_v = 17'd65536;
    e.req = '{8'd255, 8'd255}; e.has_gold = 1; e.gold = g; vecs = {vecs, e};
    e.has_gold = 0;
    e.req = '{8'd32, 8'd16}; vecs = {vecs, e};
    e.req = '{8'd31, 8'd15}; vecs = {vecs, e};
    e.req = '{8'd8, 8'd8};   vecs = {vecs, e};
    e.req = '{8'd16, 8'd4};  vecs = {vecs, e};
    e.req = '{8'd24, 8'd12}; vecs = {vecs, e};
    e.req = '{8'd170, 8'd85}; vecs = {vecs, e};
    e.req = '{8'd85, 8'd170}; vecs = {vecs, e};
    e.req = '{8'd33, 8'd0};  vecs = {vecs, e};
    foreach (vecs[i]) begin
      if (vecs[i].has_gold && vertex_of(vecs[i].req) !== vecs[i].gold) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d disagrees with prediction", i);
      end
      send_point(vecs[i].req);
    end
    drain_pipe();

    // Zero, oversize-free extreme and middle settings, then one random setting.
    seg_set = '{'{8'd0, 8'd0}, '{8'd255, 8'd255}, '{8'd1, 8'd255},
                '{8'd255, 8'd1}, '{8'd3, 8'd7}, '{8'd100, 8'd50}};
    idle_set = '{'{0, 0}, '{84, 0}, '{0, 84}, '{19, 19}};
    for (int s = 0; s < 6; s++) begin
      write_segments(seg_set[s][0], seg_set[s][1]);
      for (int ph = 0; ph < 4; ph++) begin
        send_idle_pct = idle_set[ph][0];
        recv_stall_pct = idle_set[ph][1];
        for (int n = 0; n < 61; n++) send_point(random_point());
        send_idle_pct = 0;
        for (int n = 0; n < 8; n++) send_point(random_point());
      end
      drain_pipe();
      recv_stall_pct = 0;
    end
    write_segments(8'($urandom), 8'($urandom));
    for (int n = 0; n < 80; n++) send_point(random_point());
    drain_pipe();

    if (mismatches == 0 && vertex_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: uv_sphere_vertex_gen.f
rtl/uvs_pkg.sv
rtl/uvs_div.sv
rtl/uvs_sine.sv
rtl/uv_sphere_vertex_gen.sv
tb/sv/uv_sphere_vertex_gen_tb.sv
